// ----- hw/rtl/ats_pkg.sv -----
package ats_pkg;

  // Table and script sizes
  localparam int ENTRIES       = 32;
  localparam int SCRIPT_WORDS  = 1024;
  localparam int TILE_SIZE     = 128;
  localparam int TILES_PER_ROW = 8;

  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int ENT_IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SA_W       = $clog2(SCRIPT_WORDS);
  localparam int TILE_SHIFT = $clog2(TILE_SIZE);
  localparam int ROW_SHIFT  = $clog2(TILES_PER_ROW);

  localparam logic [15:0] END_MARK = 16'hFFFF;

  // Operation codes
  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_APPEND = 3'd2;
  localparam logic [2:0] OP_TICK   = 3'd3;
  localparam logic [2:0] OP_LOOKUP = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [9:0]  script_addr;
    logic [15:0] word_value;
    logic [1:0]  layer_sel;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic [15:0] tile_base;
  } in_item_t;

  typedef struct packed {
    logic [15:0] tile_out;
    logic        substituted;
    logic        status;
  } out_item_t;

  typedef struct packed {
    logic [1:0]      layer;
    logic [15:0]     target;
    logic [SA_W-1:0] start;
    logic [SA_W-1:0] ptr;
    logic [15:0]     count;
    logic [15:0]     tile;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APP_RD1,
    S_APP_WR,
    S_TK_RD,
    S_TK_EV,
    S_TK_CHK,
    S_TK_P0,
    S_TK_P1,
    S_LK_RD,
    S_LK_SCAN,
    S_DONE
  } state_t;

endpackage

// ----- hw/rtl/ats_out_buf.sv -----
module ats_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  ats_pkg::out_item_t load_data,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output ats_pkg::out_item_t out_data
);
  import ats_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  // Take a new result when the register is empty or is being drained
  assign free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payload until the next load
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= load_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r && (out_data_r == $past(load_data)))
    else $error("loaded result not presented");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || !out_stall))
    else $error("result overwritten before transfer");

  a_drop_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(!out_stall))
    else $error("result dropped without transfer");
`endif

endmodule

// ----- hw/rtl/animated_tile_substitution.sv -----
// Clear, script write, an empty-table tick and a lookup that walks no entry go straight to
// the result; append reads hold count and first tile, then stores the entry; a lookup walks
// entries to a hit or the last; a tick counts down each active entry, reloading a pair at
// zero, from the start on an end mark. Throughput: one item in work at a time; the next
// transfer in is taken the cycle after the result loads, plus any output stall.
// Reset clears state machine, entry count and layer flags; the memories need no clearing pass.
module animated_tile_substitution (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ats_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ats_pkg::out_item_t out_data
);
  import ats_pkg::*;

  // Control state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] act_r, act_nxt;
  logic [3:0]       flags_r, flags_nxt;

  // Working registers
  in_item_t          cur_r, cur_nxt;
  logic [ENT_IW-1:0] idx_r, idx_nxt;
  entry_t            wk_r, wk_nxt;
  out_item_t         res_r, res_nxt;
  logic [15:0]       look_idx_r, look_idx_nxt;

  // Memories
  logic [15:0] script_mem [SCRIPT_WORDS];
  entry_t      entry_mem  [ENTRIES];
  logic [15:0] sm_rdata_r;
  entry_t      em_rdata_r;

  logic              sm_we;
  logic [SA_W-1:0]   sm_addr;
  logic [15:0]       sm_wdata;
  logic              em_we;
  logic              em_re;
  logic [ENT_IW-1:0] em_waddr;
  logic [ENT_IW-1:0] em_raddr;
  entry_t            em_wdata;

  // Shared decode
  logic              in_xfer;
  logic [CNT_W-1:0]  idx_inc;
  logic              more;
  logic [15:0]       count_dec;
  logic              tk_reload;
  logic              lk_hit;
  logic              res_free;
  logic [15:0]       new_idx;
  logic [SA_W-1:0]   cur_start;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign idx_inc   = CNT_W'(idx_r) + CNT_W'(1);
  assign more      = (idx_inc < act_r);
  assign count_dec = em_rdata_r.count - 16'd1;
  assign tk_reload = (count_dec == 16'd0);
  assign lk_hit    = (em_rdata_r.layer == cur_r.layer_sel) &&
                     (em_rdata_r.target == look_idx_r);
  assign cur_start = SA_W'(cur_r.script_addr);
  assign new_idx   = (16'(in_data.pos_y >> TILE_SHIFT) << ROW_SHIFT)
                   + 16'(in_data.pos_x >> TILE_SHIFT) + in_data.tile_base;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_data.op)
            OP_APPEND: state_nxt = (act_r >= CNT_W'(ENTRIES)) ? S_DONE : S_APP_RD1;
            OP_TICK:   state_nxt = (act_r == '0) ? S_DONE : S_TK_RD;
            OP_LOOKUP: begin
              state_nxt = (flags_r[in_data.layer_sel] && act_r != '0) ? S_LK_RD : S_DONE;
            end
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_APP_RD1: state_nxt = S_APP_WR;
      S_APP_WR:  state_nxt = S_DONE;
      S_TK_RD:   state_nxt = S_TK_EV;
      S_TK_EV: begin
        if (tk_reload) begin
          state_nxt = S_TK_CHK;
        end else if (!more) begin
          state_nxt = S_DONE;
        end
      end
      S_TK_CHK:  state_nxt = (sm_rdata_r == END_MARK) ? S_TK_P0 : S_TK_P1;
      S_TK_P0:   state_nxt = S_TK_P1;
      S_TK_P1:   state_nxt = more ? S_TK_RD : S_DONE;
      S_LK_RD:   state_nxt = S_LK_SCAN;
      S_LK_SCAN: begin
        if (lk_hit || !more) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    act_nxt      = act_r;
    flags_nxt    = flags_r;
    cur_nxt      = cur_r;
    idx_nxt      = idx_r;
    wk_nxt       = wk_r;
    res_nxt      = res_r;
    look_idx_nxt = look_idx_r;
    sm_we        = 1'b0;
    sm_addr      = wk_r.ptr;
    sm_wdata     = in_data.word_value;
    em_we        = 1'b0;
    em_re        = 1'b0;
    em_waddr     = idx_r;
    em_raddr     = idx_r;
    em_wdata     = wk_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cur_nxt      = in_data;
          idx_nxt      = '0;
          res_nxt      = '0;
          look_idx_nxt = new_idx;
          sm_addr      = SA_W'(in_data.script_addr);
          case (in_data.op)
            OP_CLEAR: begin
              act_nxt   = '0;
              flags_nxt = '0;
            end
            OP_WRITE: sm_we = 1'b1;
            OP_APPEND: begin
              if (act_r >= CNT_W'(ENTRIES)) begin
                res_nxt.status = 1'b1;
              end
            end
            OP_LOOKUP: res_nxt.tile_out = new_idx;
            default: ;
          endcase
        end
      end
      // Capture the hold count, fetch the first tile
      S_APP_RD1: begin
        wk_nxt.count = sm_rdata_r;
        sm_addr      = cur_start + SA_W'(1);
      end
      // Store the new entry
      S_APP_WR: begin
        em_we           = 1'b1;
        em_waddr        = ENT_IW'(act_r);
        em_wdata.layer  = cur_r.layer_sel;
        em_wdata.target = cur_r.word_value;
        em_wdata.start  = cur_start;
        em_wdata.ptr    = cur_start + SA_W'(2);
        em_wdata.count  = wk_r.count;
        em_wdata.tile   = sm_rdata_r;
        flags_nxt[cur_r.layer_sel] = 1'b1;
        act_nxt         = act_r + CNT_W'(1);
      end
      S_TK_RD: em_re = 1'b1;
      // Count down; write back, or start a reload at the read pointer
      S_TK_EV: begin
        wk_nxt       = em_rdata_r;
        wk_nxt.count = count_dec;
        if (tk_reload) begin
          sm_addr = em_rdata_r.ptr;
        end else begin
          em_we          = 1'b1;
          em_wdata       = em_rdata_r;
          em_wdata.count = count_dec;
          if (more) begin
            em_re    = 1'b1;
            em_raddr = ENT_IW'(idx_inc);
            idx_nxt  = ENT_IW'(idx_inc);
          end
        end
      end
      // Wrap to the start on the end mark, else take the word as hold count
      S_TK_CHK: begin
        if (sm_rdata_r == END_MARK) begin
          sm_addr = wk_r.start;
        end else begin
          wk_nxt.count = sm_rdata_r;
          sm_addr      = wk_r.ptr + SA_W'(1);
          wk_nxt.ptr   = wk_r.ptr + SA_W'(2);
        end
      end
      S_TK_P0: begin
        wk_nxt.count = sm_rdata_r;
        sm_addr      = wk_r.start + SA_W'(1);
        wk_nxt.ptr   = wk_r.start + SA_W'(2);
      end
      S_TK_P1: begin
        em_we         = 1'b1;
        em_wdata.tile = sm_rdata_r;
        if (more) begin
          idx_nxt = ENT_IW'(idx_inc);
        end
      end
      S_LK_RD: em_re = 1'b1;
      // Compare one entry per cycle while the next is read
      S_LK_SCAN: begin
        if (lk_hit) begin
          res_nxt.tile_out    = em_rdata_r.tile;
          res_nxt.substituted = 1'b1;
        end else if (more) begin
          em_re    = 1'b1;
          em_raddr = ENT_IW'(idx_inc);
          idx_nxt  = ENT_IW'(idx_inc);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      act_r   <= '0;
      flags_r <= '0;
    end else begin
      state_r <= state_nxt;
      act_r   <= act_nxt;
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    idx_r      <= idx_nxt;
    wk_r       <= wk_nxt;
    res_r      <= res_nxt;
    look_idx_r <= look_idx_nxt;
  end

  // Script memory: single port, registered read
  always_ff @(posedge clk) begin
    if (sm_we) begin
      script_mem[sm_addr] <= sm_wdata;
    end
    sm_rdata_r <= script_mem[sm_addr];
  end

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (em_we) begin
      entry_mem[em_waddr] <= em_wdata;
    end
    if (em_re) begin
      em_rdata_r <= entry_mem[em_raddr];
    end
  end

  ats_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (state_r == S_DONE && res_free),
    .load_data (res_r),
    .free      (res_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (em_we && em_re) |-> (em_waddr != em_raddr))
    else $error("entry read and write hit the same address");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    act_r <= CNT_W'(ENTRIES))
    else $error("entry count beyond table size");

  a_script_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sm_we |-> (state_r == S_IDLE && in_xfer))
    else $error("script write outside an accepted transfer");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r != S_IDLE)
    else $error("accepted transfer not taken into work");
`endif

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import ats_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int PHASE_ITEMS    = 320;
  localparam int HOT_MAX        = 24;
  localparam int HEADS_MAX      = 16;

  // Animation predictor and queue of tiles still owed by the block
  class tile_anim_board;
    logic [15:0] script [SCRIPT_WORDS];
    bit          written [SCRIPT_WORDS];
    logic [1:0]  ent_layer [ENTRIES];
    logic [15:0] ent_target [ENTRIES];
    int unsigned ent_start [ENTRIES];
    int unsigned ent_ptr [ENTRIES];
    logic [15:0] ent_count [ENTRIES];
    logic [15:0] ent_tile [ENTRIES];
    int unsigned n_active;
    bit          layer_on [4];
    out_item_t   tiles_due [$];
    int          errors, n_items, n_lookups, n_subst, n_ticks, n_reloads, n_refused;

    function new();
      foreach (script[i]) script[i] = '0;
    endfunction

    function void load_pair(int unsigned e);
      int unsigned p;
      p = ent_ptr[e] % SCRIPT_WORDS;
      ent_count[e] = script[p];
      p = (p + 1) % SCRIPT_WORDS;
      ent_tile[e] = script[p];
      ent_ptr[e] = (p + 1) % SCRIPT_WORDS;
    endfunction

    function out_item_t animate_step(in_item_t it);
      out_item_t   r;
      logic [15:0] idx;
      int unsigned e;
      r = '0;
      case (it.op)
        OP_CLEAR: begin
          n_active = 0;
          foreach (layer_on[i]) layer_on[i] = 1'b0;
        end
        OP_WRITE: begin
          script[it.script_addr]  = it.word_value;
          written[it.script_addr] = 1'b1;
        end
        OP_APPEND: begin
          if (n_active >= ENTRIES) begin
            r.status = 1'b1;
            n_refused++;
          end else begin
            e = n_active;
            ent_layer[e]  = it.layer_sel;
            ent_target[e] = it.word_value;
            ent_start[e]  = it.script_addr;
            ent_ptr[e]    = it.script_addr;
            load_pair(e);
            layer_on[it.layer_sel] = 1'b1;
            n_active = e + 1;
          end
        end
        OP_TICK: begin
          n_ticks++;
          for (int unsigned i = 0; i < n_active; i++) begin
            ent_count[i] = ent_count[i] - 16'd1;
            if (ent_count[i] == 16'd0) begin
              // an end mark in the count slot sends the entry back to its start
              if (script[ent_ptr[i]] == END_MARK) ent_ptr[i] = ent_start[i];
              load_pair(i);
              n_reloads++;
            end
          end
        end
        OP_LOOKUP: begin
          n_lookups++;
          idx = 16'((it.pos_y / TILE_SIZE) * TILES_PER_ROW + it.pos_x / TILE_SIZE
                    + it.tile_base);
          r.tile_out = idx;
          if (layer_on[it.layer_sel]) begin
            for (int unsigned i = 0; i < n_active; i++) begin
              if (ent_layer[i] == it.layer_sel && ent_target[i] == idx) begin
                r.tile_out    = ent_tile[i];
                r.substituted = 1'b1;
                n_subst++;
                break;
              end
            end
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void log_item(in_item_t it);
      n_items++;
      tiles_due.push_back(animate_step(it));
    endfunction

    function void match_tile(out_item_t got);
      out_item_t want;
      if (tiles_due.size() == 0) begin
        $error("result with no item waiting: tile_out %h substituted %b status %b",
               got.tile_out, got.substituted, got.status);
        errors++;
        return;
      end
      want = tiles_due.pop_front();
      if (got.tile_out !== want.tile_out) begin
        $error("tile_out: expected %h, got %h", want.tile_out, got.tile_out);
        errors++;
      end
      if (got.substituted !== want.substituted) begin
        $error("substituted: expected %b, got %b", want.substituted, got.substituted);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %b, got %b", want.status, got.status);
        errors++;
      end
    endfunction

    function bit pair_written(int unsigned q);
      return written[q % SCRIPT_WORDS] && written[(q + 1) % SCRIPT_WORDS];
    endfunction

    // Walk every word an entry can still read; fail on any unwritten word
    function bit chain_safe(int unsigned p, int unsigned s, bit from_start);
      int unsigned q;
      int          jumps;
      q = p % SCRIPT_WORDS;
      jumps = from_start ? 1 : 0;
      if (from_start) begin
        if (!pair_written(q)) return 1'b0;
        q = (q + 2) % SCRIPT_WORDS;
      end
      for (int k = 0; k < 2 * SCRIPT_WORDS; k++) begin
        if (!written[q]) return 1'b0;
        if (script[q] == END_MARK) begin
          if (jumps > 0) return 1'b1;
          jumps = 1;
          q = s;
          if (!pair_written(q)) return 1'b0;
        end else if (!written[(q + 1) % SCRIPT_WORDS]) begin
          return 1'b0;
        end
        q = (q + 2) % SCRIPT_WORDS;
      end
      return 1'b1;
    endfunction

    // Refuse items that would let any entry read script memory never written
    function bit item_safe(in_item_t it);
      logic [15:0] old_word;
      bit          old_written;
      bit          ok;
      ok = 1'b1;
      if (it.op == OP_APPEND) begin
        if (n_active < ENTRIES) ok = chain_safe(it.script_addr, it.script_addr, 1'b1);
      end else if (it.op == OP_WRITE) begin
        old_word    = script[it.script_addr];
        old_written = written[it.script_addr];
        script[it.script_addr]  = it.word_value;
        written[it.script_addr] = 1'b1;
        for (int unsigned i = 0; i < n_active && ok; i++)
          ok = chain_safe(ent_ptr[i], ent_start[i], 1'b0);
        script[it.script_addr]  = old_word;
        written[it.script_addr] = old_written;
      end
      return ok;
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      out_stall = 1'b0;
  in_item_t  in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  tile_anim_board board;
  int             idle_pct   = 0;
  int             stall_pct  = 0;
  int             sent_items = 0;
  int             quiet_cycles = 0;
  logic [17:0]    hot_spots [$];
  logic [9:0]     list_heads [$];

  always #10 clk = ~clk;

  animated_tile_substitution u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Note each transfer on both channels
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.log_item(in_data);
    if (rst_n && out_valid && !out_stall) board.match_tile(out_data);
  end

  // Stall the result channel at the current rate
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // End the run when nothing moves for too long
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  function automatic in_item_t rand_item(logic [2:0] op);
    in_item_t it;
    it.op          = op;
    it.script_addr = 10'($urandom_range(1023));
    it.word_value  = 16'($urandom_range(65535));
    it.layer_sel   = 2'($urandom_range(3));
    it.pos_x       = 10'($urandom_range(1023));
    it.pos_y       = 10'($urandom_range(1023));
    it.tile_base   = 16'($urandom_range(65535));
    return it;
  endfunction

  function automatic logic [15:0] pick_hold();
    int r;
    r = $urandom_range(99);
    if (r < 80) return 16'($urandom_range(4, 1));
    if (r < 88) return 16'd0;
    if (r < 95) return 16'($urandom_range(20, 5));
    return 16'($urandom_range(65535));
  endfunction

  // Present one item and hold it until the transfer; unsafe items are dropped
  task automatic send_item(in_item_t it);
    if (!board.item_safe(it)) return;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (it.op <= OP_LOOKUP) sent_items++;
  endtask

  task automatic send_op(logic [2:0] op);
    send_item(rand_item(op));
  endtask

  task automatic put_word(logic [9:0] addr, logic [15:0] word);
    in_item_t it;
    it = rand_item(OP_WRITE);
    it.script_addr = addr;
    it.word_value  = word;
    send_item(it);
  endtask

  task automatic put_entry(logic [9:0] start, logic [1:0] layer, logic [15:0] target);
    in_item_t it;
    it = rand_item(OP_APPEND);
    it.script_addr = start;
    it.layer_sel   = layer;
    it.word_value  = target;
    hot_spots.push_back({layer, target});
    if (hot_spots.size() > HOT_MAX) void'(hot_spots.pop_front());
    send_item(it);
  endtask

  task automatic look(logic [1:0] layer, logic [9:0] px, logic [9:0] py, logic [15:0] base);
    in_item_t it;
    it = rand_item(OP_LOOKUP);
    it.layer_sel = layer;
    it.pos_x     = px;
    it.pos_y     = py;
    it.tile_base = base;
    send_item(it);
  endtask

  // Aim a lookup at a known target from a random pixel position
  task automatic probe(logic [17:0] spot);
    logic [9:0]  px, py;
    logic [15:0] grid;
    px = 10'($urandom_range(1023));
    py = 10'($urandom_range(1023));
    grid = 16'((py / TILE_SIZE) * TILES_PER_ROW + px / TILE_SIZE);
    look(spot[17:16], px, py, spot[15:0] - grid);
  endtask

  // Write a list of (hold, tile) pairs closed by an end mark
  task automatic build_list(logic [9:0] base, int npairs);
    for (int k = 0; k < npairs; k++) begin
      put_word(base + 10'(2 * k), pick_hold());
      put_word(base + 10'(2 * k + 1), 16'($urandom_range(65535)));
    end
    put_word(base + 10'(2 * npairs), END_MARK);
    list_heads.push_back(base);
    if (list_heads.size() > HEADS_MAX) void'(list_heads.pop_front());
  endtask

  task automatic run_phase(int goal);
    int         r, n, guard, first_count;
    logic [9:0] base;
    first_count = sent_items;
    while (sent_items - first_count < goal) begin
      r = $urandom_range(99);
      if (r < 8 || list_heads.size() == 0) begin
        base = 10'($urandom_range(1023));
        build_list(base, $urandom_range(4, 1));
        n = $urandom_range(3, 1);
        repeat (n) put_entry(base, 2'($urandom_range(3)), 16'($urandom_range(65535)));
      end else if (r < 18) begin
        put_entry(list_heads[$urandom_range(list_heads.size() - 1)],
                  2'($urandom_range(3)), 16'($urandom_range(65535)));
      end else if (r < 20) begin
        // fill the table, then push two appends past the end
        guard = 0;
        while (board.n_active < ENTRIES && guard < 48) begin
          put_entry(list_heads[$urandom_range(list_heads.size() - 1)],
                    2'($urandom_range(3)), 16'($urandom_range(65535)));
          guard++;
        end
        repeat (2) send_op(OP_APPEND);
      end else if (r < 45) begin
        n = $urandom_range(4, 1);
        repeat (n) send_op(OP_TICK);
      end else if (r < 80) begin
        if (hot_spots.size() != 0 && $urandom_range(3) != 0)
          probe(hot_spots[$urandom_range(hot_spots.size() - 1)]);
        else
          send_op(OP_LOOKUP);
      end else if (r < 93) begin
        put_word(10'($urandom_range(1023)),
                 ($urandom_range(3) == 0) ? END_MARK : 16'($urandom_range(65535)));
      end else if (r < 95) begin
        send_op(OP_CLEAR);
      end else if (r < 97) begin
        send_op(3'($urandom_range(7, 5)));
      end else begin
        send_op(OP_APPEND);
      end
    end
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: lookups on an empty table at the field extremes
    look(2'd0, 10'd1023, 10'd1023, 16'hFFFF);
    look(2'd1, 10'd0, 10'd0, 16'h0000);

    // list across the top of the script memory, end mark wrapped to word zero
    put_word(10'd1020, 16'd1);
    put_word(10'd1021, 16'hA5A5);
    put_word(10'd1022, 16'd2);
    put_word(10'd1023, 16'h5A5A);
    put_word(10'd0, END_MARK);
    put_entry(10'd1020, 2'd3, 16'hFFFF);
    look(2'd3, 10'd0, 10'd0, 16'hFFFF);
    look(2'd2, 10'd0, 10'd0, 16'hFFFF);
    send_op(OP_TICK);
    look(2'd3, 10'd127, 10'd127, 16'hFFFF);
    send_op(OP_TICK);
    send_op(OP_TICK);
    look(2'd3, 10'd0, 10'd0, 16'hFFFF);

    // zero hold count wraps the countdown instead of reloading
    put_word(10'd100, 16'd0);
    put_word(10'd101, 16'h1234);
    put_word(10'd102, END_MARK);
    put_entry(10'd100, 2'd0, 16'd9);
    send_op(OP_TICK);
    look(2'd0, 10'd128, 10'd128, 16'h0000);

    // unused codes, then clear drops every entry
    send_op(3'd5);
    send_op(3'd6);
    send_op(3'd7);
    send_op(OP_CLEAR);
    look(2'd3, 10'd0, 10'd0, 16'hFFFF);
    list_heads.push_back(10'd1020);
    list_heads.push_back(10'd100);

    // Random phases under different idle and stall mixes
    idle_pct = 0;  stall_pct = 0;  run_phase(PHASE_ITEMS);
    idle_pct = 62; stall_pct = 0;  run_phase(PHASE_ITEMS);
    idle_pct = 0;  stall_pct = 62; run_phase(PHASE_ITEMS);
    idle_pct = 36; stall_pct = 36; run_phase(PHASE_ITEMS);
    in_valid <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (board.tiles_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d transfers in: %0d lookups (%0d substituted), %0d ticks",
             board.n_items, board.n_lookups, board.n_subst, board.n_ticks);
    $display("with %0d pair reloads, %0d appends refused on a full table, %0d mismatches.",
             board.n_reloads, board.n_refused, board.errors);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
